/* sv/modexp_pkg.sv */
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;

	localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MULT,
		ST_SQUARE,
		ST_FINISH
	} state_t;

endpackage

/* sv/modexp_mulmod.sv */
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module modexp_mulmod import modexp_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [OPERAND_WIDTH-1:0] x,
	input  logic [OPERAND_WIDTH-1:0] y,
	input  logic [OPERAND_WIDTH-1:0] m,
	output logic                     done,
	output logic [OPERAND_WIDTH-1:0] product
);

	localparam int unsigned W     = OPERAND_WIDTH;
	localparam int unsigned CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     y_q;
	logic [W-1:0]     acc_q;

	logic [W:0]   dbl;
	logic [W:0]   dbl_sub;
	logic [W-1:0] dbl_red;
	logic [W-1:0] addend;
	logic [W:0]   sum;
	logic [W:0]   sum_sub;
	logic [W-1:0] acc_next;

	// acc = 2*acc mod m, then + x mod m when the current bit of y is set
	always_comb begin
		dbl      = {acc_q, 1'b0};
		dbl_sub  = dbl - {1'b0, m};
		dbl_red  = (dbl >= {1'b0, m}) ? dbl_sub[W-1:0] : dbl[W-1:0];
		addend   = y_q[W-1] ? x : '0;
		sum      = {1'b0, dbl_red} + {1'b0, addend};
		sum_sub  = sum - {1'b0, m};
		acc_next = (sum >= {1'b0, m}) ? sum_sub[W-1:0] : sum[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			y_q   <= {y_q[W-2:0], 1'b0};
			acc_q <= acc_next;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

/* sv/modular_exponentiation.sv */
// Top level of the modular exponentiation block.
// Computes base_value ** exponent_value mod modulus_value by right-to-left
// square-and-multiply; a zero exponent gives 1 and a zero modulus gives 0 with
// zero_modulus_error set. One transaction is worked on at a time. Time per item
// is set by the single bit-serial modular multiplier, which forms every product:
// first it reduces the base, then for each exponent bit up to the highest set
// one there is a step state, for a set bit a multiply, and a square, followed
// by the last step and finish; a zero modulus skips the multiplier and goes
// straight to finish. The result sits in an output register, so the next
// transaction may be taken while it waits.
module modular_exponentiation import modexp_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OPERAND_WIDTH-1:0] base_value,
	input  logic [OPERAND_WIDTH-1:0] exponent_value,
	input  logic [OPERAND_WIDTH-1:0] modulus_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [OPERAND_WIDTH-1:0] power_result,
	output logic                     zero_modulus_error
);

	localparam int unsigned W = OPERAND_WIDTH;

	state_t state_q;
	state_t state_next;

	logic [W-1:0] expo_q;
	logic [W-1:0] mod_q;
	logic [W-1:0] result_q;
	logic [W-1:0] square_q;
	logic         err_q;

	logic         out_valid_q;
	logic [W-1:0] out_result_q;
	logic         out_err_q;

	logic         in_fire;
	logic         out_free;
	logic         mod_zero;

	logic         mm_start;
	logic [W-1:0] mm_x;
	logic [W-1:0] mm_y;
	logic [W-1:0] mm_m;
	logic         mm_done;
	logic [W-1:0] mm_product;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign mod_zero = (modulus_value == '0);

	modexp_mulmod #(
		.OPERAND_WIDTH(W)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.x       (mm_x),
		.y       (mm_y),
		.m       (mm_m),
		.done    (mm_done),
		.product (mm_product)
	);

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_next = mod_zero ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					state_next = ST_STEP;
				end
			end
			ST_STEP: begin
				priority if (expo_q == '0) begin
					state_next = ST_FINISH;
				end else if (expo_q[0]) begin
					state_next = ST_MULT;
				end else begin
					state_next = ST_SQUARE;
				end
			end
			ST_MULT: begin
				if (mm_done) begin
					state_next = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (mm_done) begin
					state_next = ST_STEP;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// multiplier control; the base is reduced as 1 * base mod m
	always_comb begin
		mm_start = 1'b0;
		mm_x     = square_q;
		mm_y     = square_q;
		mm_m     = mod_q;
		unique case (state_q)
			ST_IDLE: begin
				mm_start = in_fire && !mod_zero;
				mm_x     = W'(1);
				mm_y     = base_value;
			end
			ST_REDUCE: begin
				mm_x = W'(1);
			end
			ST_STEP: begin
				mm_start = (expo_q != '0);
			end
			ST_MULT: begin
				mm_start = mm_done;
				mm_x     = result_q;
			end
			ST_SQUARE: begin
				mm_x = square_q;
			end
			ST_FINISH: begin
				mm_x = square_q;
			end
			default: mm_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					expo_q   <= exponent_value;
					mod_q    <= modulus_value;
					result_q <= mod_zero ? '0 : W'(1);
					err_q    <= mod_zero;
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					square_q <= mm_product;
				end
			end
			ST_STEP: begin
				// nothing to store
			end
			ST_MULT: begin
				if (mm_done) begin
					result_q <= mm_product;
				end
			end
			ST_SQUARE: begin
				if (mm_done) begin
					square_q <= mm_product;
					expo_q   <= {1'b0, expo_q[W-1:1]};
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_result_q <= result_q;
					out_err_q    <= err_q;
				end
			end
			default: begin
				// unreachable
			end
		endcase
	end

	assign out_valid          = out_valid_q;
	assign power_result       = out_result_q;
	assign zero_modulus_error = out_err_q;

endmodule
